### hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int NUM_DENOMS = 7;
  localparam int COUNT_W    = 16;
  localparam int AMOUNT_W   = 16;
  localparam int VALUE_W    = 10;
  localparam int IDX_W      = 3;
  localparam int MAGIC_W    = 17;
  localparam int SHIFT_W    = 5;
  localparam int PROD_W     = AMOUNT_W + MAGIC_W;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_REMOVE,
    ACT_CHANGE,
    ACT_NONE
  } action_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_EMPTY,
    ST_SATURATED
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOTE,
    S_DIV,
    S_PAY,
    S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic note_upd;
    logic div_step;
    logic pay_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_denom;
  } sts_t;

  // face value of each denomination, smallest first
  function automatic logic [VALUE_W-1:0] denom_val(idx_t i);
    logic [VALUE_W-1:0] v;
    case (i)
      3'd0:    v = 10'd1;
      3'd1:    v = 10'd5;
      3'd2:    v = 10'd10;
      3'd3:    v = 10'd50;
      3'd4:    v = 10'd100;
      3'd5:    v = 10'd200;
      3'd6:    v = 10'd500;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

  // reciprocal ceil(2^(16+l)/d), l = ceil(log2 d): exact quotient for 16-bit dividends
  function automatic logic [MAGIC_W-1:0] denom_magic(idx_t i);
    logic [MAGIC_W-1:0] m;
    case (i)
      3'd0:    m = 17'd65536;
      3'd1:    m = 17'd104858;
      3'd2:    m = 17'd104858;
      3'd3:    m = 17'd83887;
      3'd4:    m = 17'd83887;
      3'd5:    m = 17'd83887;
      3'd6:    m = 17'd67109;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

  function automatic logic [SHIFT_W-1:0] denom_shift(idx_t i);
    logic [SHIFT_W-1:0] s;
    case (i)
      3'd0:    s = 5'd16;
      3'd1:    s = 5'd19;
      3'd2:    s = 5'd20;
      3'd3:    s = 5'd22;
      3'd4:    s = 5'd23;
      3'd5:    s = 5'd24;
      3'd6:    s = 5'd25;
      default: s = 5'd16;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/gcd_dp.sv
`timescale 1ns / 1ps

module gcd_dp import gcd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  action_t             action,
  input  logic [VALUE_W-1:0]  note_value,
  input  logic [AMOUNT_W-1:0] change_amount,
  output status_t             out_status,
  output logic [COUNT_W-1:0]  out_paid [NUM_DENOMS],
  output logic [AMOUNT_W-1:0] out_unpaid
);

  logic [COUNT_W-1:0]  counts [NUM_DENOMS];
  logic [COUNT_W-1:0]  paid   [NUM_DENOMS];
  action_t             act;
  logic                note_ok;
  idx_t                idx;
  logic [AMOUNT_W-1:0] rem;
  logic [AMOUNT_W-1:0] want;
  status_t             status_r;

  logic                found;
  idx_t                fidx;
  logic [COUNT_W-1:0]  cur;
  logic [COUNT_W-1:0]  take;
  logic [PROD_W-1:0]   prod;
  logic [COUNT_W+VALUE_W-1:0] pay_amt;

  // denomination lookup
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (note_value == denom_val(IDX_W'(i))) begin
        found = 1'b1;
        fidx  = IDX_W'(i);
      end
    end
  end

  assign cur     = counts[idx];
  assign prod    = PROD_W'(rem) * PROD_W'(denom_magic(idx));
  assign take    = ({{(AMOUNT_W){1'b0}}, want} < {{(COUNT_W){1'b0}}, cur}) ?
                   COUNT_W'(want) : cur;
  assign pay_amt = (COUNT_W+VALUE_W)'(take) * (COUNT_W+VALUE_W)'(denom_val(idx));
  assign sts.last_denom = (idx == '0);

  // note counts: control state, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) counts[i] <= '0;
    end else if (cmd.note_upd && note_ok) begin
      if (act == ACT_INSERT) begin
        if (cur != '1) counts[idx] <= cur + COUNT_W'(1);
      end else if (cur != '0) begin
        counts[idx] <= cur - COUNT_W'(1);
      end
    end else if (cmd.pay_step) begin
      counts[idx] <= cur - take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= action;
      note_ok  <= found;
      idx      <= (action == ACT_CHANGE) ? IDX_W'(NUM_DENOMS - 1) : fidx;
      rem      <= (action == ACT_CHANGE) ? change_amount : '0;
      status_r <= ST_OK;
      for (int i = 0; i < NUM_DENOMS; i++) paid[i] <= '0;
    end
    if (cmd.note_upd) begin
      if (!note_ok) status_r <= ST_INVALID;
      else if (act == ACT_INSERT && cur == '1) status_r <= ST_SATURATED;
      else if (act == ACT_REMOVE && cur == '0) status_r <= ST_EMPTY;
    end
    if (cmd.div_step) begin
      want <= AMOUNT_W'(prod >> denom_shift(idx));
    end
    if (cmd.pay_step) begin
      rem       <= rem - AMOUNT_W'(pay_amt);
      paid[idx] <= take;
      idx       <= idx - IDX_W'(1);
    end
    if (cmd.out_load) begin
      out_status <= status_r;
      out_paid   <= paid;
      out_unpaid <= rem;
    end
  end

endmodule

### hw/rtl/gcd_ctrl.sv
`timescale 1ns / 1ps

module gcd_ctrl import gcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  action_t action,
  output logic    m_tvalid,
  input  logic    m_tready,
  output cmd_t    cmd,
  input  sts_t    sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (action == ACT_INSERT || action == ACT_REMOVE) state_next = S_NOTE;
          else if (action == ACT_CHANGE) state_next = S_DIV;
          else state_next = S_FIN;
        end
      end
      S_NOTE: begin
        cmd.note_upd = 1'b1;
        state_next   = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_PAY;
      end
      S_PAY: begin
        cmd.pay_step = 1'b1;
        state_next   = sts.last_denom ? S_FIN : S_DIV;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous still in work");

  a_div_then_pay: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_PAY))
    else $error("quotient step not followed by pay step");

  a_last_pay_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAY && sts.last_denom) |=> (state == S_FIN))
    else $error("change walk did not end after smallest note");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded but not offered");
`endif

endmodule

### hw/rtl/greedy_change_dispenser_top.sv
`timescale 1ns / 1ps

// greedy change dispenser: holds a 16-bit count of notes for each of the
// denominations 1, 5, 10, 50, 100, 200 and 500, all zero after reset.
// each request gives exactly one result. insert (action 0) and remove
// (action 1) update the count of their note, then give their result;
// action 3 is ignored and goes straight to its result. pay change
// (action 2) walks the denominations from 500 down to 1, each with a
// reciprocal multiply for the quotient and then a take/multiply/subtract
// step, and then gives its result. the next request is taken as soon as
// the result has moved into the output register, even if the consumer
// has not yet taken it. the result status is in m_tuser; paid counts and
// the unpaid remainder are in m_tdata.

module greedy_change_dispenser_top import gcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // note_value[9:0], change_amount[25:10], zero pad
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // paid_500, paid_200, paid_100, paid_50, paid_10,
                                  // paid_5, paid_1, unpaid_remainder (16 bits each)
  output logic [1:0]   m_tuser    // status[1:0]
);

  cmd_t                cmd;
  sts_t                sts;
  action_t             action;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_paid [NUM_DENOMS];
  logic [AMOUNT_W-1:0] out_unpaid;

  assign action = action_t'(s_tuser);

  // sequencer: accepts a request, steps the datapath, hands off the result
  gcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (action),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // note counts, change arithmetic and output register
  gcd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (action),
    .note_value    (s_tdata[VALUE_W-1:0]),
    .change_amount (s_tdata[VALUE_W +: AMOUNT_W]),
    .out_status    (out_status),
    .out_paid      (out_paid),
    .out_unpaid    (out_unpaid)
  );

  // largest denomination in the lowest bits, unpaid remainder in the top bits
  assign m_tdata = {out_unpaid, out_paid[0], out_paid[1], out_paid[2], out_paid[3],
                    out_paid[4], out_paid[5], out_paid[6]};
  assign m_tuser = out_status;

endmodule
